// ----- src/stack_bytecode_executor_defines.svh -----
// assertion macros for the stack bytecode executor
`ifndef STACK_BYTECODE_EXECUTOR_DEFINES_SVH
`define STACK_BYTECODE_EXECUTOR_DEFINES_SVH

// assert that a condition implies a property on the same edge
`define SBE_ASSERT_IMPL(label, clk_s, rst_s, cond, prop, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (cond) |-> (prop)) \
    else $error(msg);

// assert that a condition implies a property on the next edge
`define SBE_ASSERT_NEXT(label, clk_s, rst_s, cond, prop, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (cond) |=> (prop)) \
    else $error(msg);

`endif

// ----- src/sbe_pkg.sv -----
package sbe_pkg;

  localparam int DefStackDepth = 256;
  localparam int DefStoreDepth = 256;
  localparam int PrintMax      = 64;

  typedef enum logic [3:0] {
    OP_HALT = 4'd0, OP_GETL = 4'd1, OP_SETL = 4'd2, OP_GETG = 4'd3,
    OP_SETG = 4'd4, OP_PUSH = 4'd5, OP_CALL = 4'd6, OP_RET = 4'd7,
    OP_ADD = 4'd8, OP_SUB = 4'd9, OP_MUL = 4'd10, OP_DIV = 4'd11,
    OP_NEG = 4'd12, OP_SHOW = 4'd13
  } opcode_t;

  typedef enum logic [1:0] {
    KIND_PRINT = 2'd0, KIND_HALT = 2'd1, KIND_ERROR = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ERR_OVERFLOW = 3'd0, ERR_UNDERFLOW = 3'd1, ERR_DIV_ZERO = 3'd2,
    ERR_INDEX = 3'd3, ERR_UNSUPPORTED = 3'd4
  } err_t;

endpackage

// ----- src/stack_bytecode_executor.sv -----
// stack bytecode executor: one instruction per transaction, one at a time
// division is restoring, one quotient bit per cycle in the shared add/subtract unit;
// print gives one result per value; output stalls hold the executor until taken
// reset: synchronous, clears stack pointer and halt flag, then a clearing pass
// over all STORE_DEPTH entries zeroes the variable store before the first transaction
module stack_bytecode_executor
  import sbe_pkg::*;
#(
  parameter int STACK_DEPTH = DefStackDepth,
  parameter int STORE_DEPTH = DefStoreDepth
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [3:0]         op,
  input  logic signed [31:0] arg,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         kind,
  output logic [2:0]         error_code,
  output logic signed [31:0] value,
  output logic               last
);

`include "stack_bytecode_executor_defines.svh"

  localparam int SpW = $clog2(STACK_DEPTH + 1);
  localparam int SaW = $clog2(STACK_DEPTH);
  localparam int VaW = $clog2(STORE_DEPTH);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DECODE, S_RD_B, S_RD_A, S_EXEC, S_DIV, S_DIV_FIX,
    S_WRITE, S_VRD, S_PRD, S_EMIT, S_OUT
  } state_t;

  state_t            state;
  logic [SpW-1:0]    sp;
  logic              halted;
  logic [VaW-1:0]    clr_idx;
  logic [3:0]        op_r;
  logic [31:0]       arg_r;
  logic [31:0]       opb, res;
  logic [6:0]        pcnt, pidx;
  logic              print_mode;
  // divider state
  logic [31:0]       rem, quo, dvs;
  logic [5:0]        dcnt;
  logic              qneg;

  // memories
  logic [31:0] stk [STACK_DEPTH];
  logic [31:0] vst [STORE_DEPTH];
  logic [31:0] stk_q, vst_q;
  logic              stk_we, vst_we;
  logic [SaW-1:0]    stk_addr;
  logic [VaW-1:0]    vst_addr;
  logic [31:0]       stk_wd, vst_wd;

  always_ff @(posedge clk) begin
    if (stk_we) stk[stk_addr] <= stk_wd;
    stk_q <= stk[stk_addr];
  end

  always_ff @(posedge clk) begin
    if (vst_we) vst[vst_addr] <= vst_wd;
    vst_q <= vst[vst_addr];
  end

  logic idx_bad;
  assign idx_bad = (arg_r >= 32'(STORE_DEPTH));

  // shared add/subtract unit
  logic [31:0] alu_x, alu_y, alu_s;
  logic        alu_sub;
  logic [32:0] alu_full;
  assign alu_full = {1'b0, alu_x} + {1'b0, (alu_sub ? ~alu_y : alu_y)} + 33'(alu_sub);
  assign alu_s = alu_full[31:0];

  logic [31:0] rem_sh;
  assign rem_sh = {rem[30:0], quo[31]};

  always_comb begin
    alu_x = stk_q; alu_y = opb; alu_sub = 1'b0;
    unique case (state)
      S_DIV:     begin alu_x = rem_sh; alu_y = dvs; alu_sub = 1'b1; end
      S_DIV_FIX: begin alu_x = 32'd0; alu_y = quo; alu_sub = 1'b1; end
      S_EXEC:    begin
        alu_sub = (op_r == OP_SUB) || (op_r == OP_NEG);
        if (op_r == OP_NEG) begin alu_x = 32'd0; alu_y = stk_q; end
      end
      default: ;
    endcase
  end

  // memory port control
  always_comb begin
    stk_we = 1'b0; stk_addr = sp[SaW-1:0]; stk_wd = res;
    vst_we = 1'b0; vst_addr = arg_r[VaW-1:0]; vst_wd = stk_q;
    unique case (state)
      S_CLEAR: begin vst_we = 1'b1; vst_addr = clr_idx; vst_wd = 32'd0; end
      S_RD_B:  stk_addr = SaW'(sp - SpW'(1));
      S_RD_A:  stk_addr = SaW'(sp - SpW'(2));
      S_PRD:   stk_addr = SaW'(sp - SpW'(pcnt) + SpW'(pidx));
      S_WRITE: begin
        unique case (op_r)
          OP_SETL, OP_SETG: begin vst_we = 1'b1; end
          OP_PUSH: begin stk_we = 1'b1; stk_wd = arg_r; end
          OP_GETL, OP_GETG: begin stk_we = 1'b1; stk_wd = vst_q; end
          OP_NEG: begin stk_we = 1'b1; stk_addr = SaW'(sp - SpW'(1)); end
          default: begin stk_we = 1'b1; stk_addr = SaW'(sp - SpW'(1)); end
        endcase
      end
      default: ;
    endcase
  end

  logic out_fire;
  assign out_fire = out_valid && out_ready;
  assign in_ready = (state == S_IDLE);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR; sp <= '0; halted <= 1'b0; clr_idx <= '0; out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + VaW'(1);
          if (clr_idx == VaW'(STORE_DEPTH - 1)) state <= S_IDLE;
        end
        S_IDLE: if (in_valid) begin
          op_r <= op; arg_r <= arg; print_mode <= 1'b0;
          if (!halted) state <= S_DECODE;
        end
        S_DECODE: begin
          kind <= (op_r == OP_HALT) ? KIND_HALT : KIND_ERROR;
          value <= 32'd0; last <= 1'b1;
          unique case (op_r)
            OP_HALT: begin
              error_code <= ERR_OVERFLOW;
              halted <= 1'b1; out_valid <= 1'b1; state <= S_OUT;
            end
            OP_GETL, OP_GETG: begin
              if (idx_bad) begin
                error_code <= ERR_INDEX; halted <= 1'b1; out_valid <= 1'b1; state <= S_OUT;
              end else if (sp >= SpW'(STACK_DEPTH)) begin
                error_code <= ERR_OVERFLOW; halted <= 1'b1; out_valid <= 1'b1;
                state <= S_OUT;
              end else state <= S_VRD;
            end
            OP_SETL, OP_SETG: begin
              if (idx_bad) begin
                error_code <= ERR_INDEX; halted <= 1'b1; out_valid <= 1'b1; state <= S_OUT;
              end else if (sp == '0) begin
                error_code <= ERR_UNDERFLOW; halted <= 1'b1; out_valid <= 1'b1;
                state <= S_OUT;
              end else state <= S_RD_B;
            end
            OP_PUSH: begin
              if (sp >= SpW'(STACK_DEPTH)) begin
                error_code <= ERR_OVERFLOW; halted <= 1'b1; out_valid <= 1'b1;
                state <= S_OUT;
              end else state <= S_WRITE;
            end
            OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
              if (sp < SpW'(2)) begin
                error_code <= ERR_UNDERFLOW; halted <= 1'b1; out_valid <= 1'b1;
                state <= S_OUT;
              end else state <= S_RD_B;
            end
            OP_NEG: begin
              if (sp == '0) begin
                error_code <= ERR_UNDERFLOW; halted <= 1'b1; out_valid <= 1'b1;
                state <= S_OUT;
              end else state <= S_RD_B;
            end
            OP_SHOW: begin
              if (arg_r > 32'(PrintMax)) begin
                error_code <= ERR_INDEX; halted <= 1'b1; out_valid <= 1'b1; state <= S_OUT;
              end else if (arg_r > 32'(sp)) begin
                error_code <= ERR_UNDERFLOW; halted <= 1'b1; out_valid <= 1'b1;
                state <= S_OUT;
              end else if (arg_r == 32'd0) state <= S_IDLE;
              else begin
                pcnt <= arg_r[6:0]; pidx <= '0; print_mode <= 1'b1; state <= S_PRD;
              end
            end
            default: begin
              error_code <= ERR_UNSUPPORTED; halted <= 1'b1; out_valid <= 1'b1;
              state <= S_OUT;
            end
          endcase
        end
        S_VRD: state <= S_WRITE;
        S_RD_B: begin
          if (op_r == OP_SETL || op_r == OP_SETG) begin
            sp <= sp - SpW'(1); state <= S_WRITE;
          end else if (op_r == OP_NEG) state <= S_EXEC;
          else state <= S_RD_A;
        end
        S_RD_A: begin opb <= stk_q; state <= S_EXEC; end
        S_EXEC: begin
          if (op_r == OP_NEG) begin
            res <= alu_s; state <= S_WRITE;
          end else begin
            if (op_r == OP_DIV) begin
              if (opb == 32'd0) begin
                kind <= KIND_ERROR; error_code <= ERR_DIV_ZERO; halted <= 1'b1;
                out_valid <= 1'b1; state <= S_OUT;
              end else begin
                qneg <= stk_q[31] ^ opb[31];
                quo <= stk_q[31] ? 32'd0 - stk_q : stk_q;
                dvs <= opb[31] ? 32'd0 - opb : opb;
                rem <= '0; dcnt <= '0; state <= S_DIV;
              end
            end else begin
              unique case (op_r)
                OP_ADD, OP_SUB: res <= alu_s;
                default:        res <= stk_q * opb;
              endcase
              sp <= sp - SpW'(1); state <= S_WRITE;
            end
          end
        end
        S_DIV: begin
          // restoring division, one bit per cycle
          if (alu_full[32]) rem <= alu_s;
          else rem <= rem_sh;
          quo <= {quo[30:0], alu_full[32]};
          dcnt <= dcnt + 6'd1;
          if (dcnt == 6'd31) state <= S_DIV_FIX;
        end
        S_DIV_FIX: begin
          res <= qneg ? alu_s : quo; sp <= sp - SpW'(1); state <= S_WRITE;
        end
        S_WRITE: begin
          if (op_r == OP_PUSH || op_r == OP_GETL || op_r == OP_GETG) sp <= sp + SpW'(1);
          state <= S_IDLE;
        end
        S_PRD: state <= S_EMIT;
        S_EMIT: begin
          kind <= KIND_PRINT; error_code <= ERR_OVERFLOW; value <= stk_q;
          last <= (pidx + 7'd1 == pcnt); out_valid <= 1'b1; state <= S_OUT;
        end
        S_OUT: if (out_fire) begin
          out_valid <= 1'b0;
          if (print_mode && !last) begin
            pidx <= pidx + 7'd1; state <= S_PRD;
          end else begin
            if (print_mode) sp <= sp - SpW'(pcnt);
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `SBE_ASSERT_IMPL(a_ready_idle, clk, rst, in_ready, out_valid == 1'b0, "ready with result")
  `SBE_ASSERT_IMPL(a_sp_range, clk, rst, 1'b1, sp <= SpW'(STACK_DEPTH), "sp out of range")
  `SBE_ASSERT_NEXT(a_halt_sticky, clk, rst, halted, halted, "halt flag dropped")

endmodule

// ----- bench/stack_bytecode_executor_tb.sv -----
module stack_bytecode_executor_tb;
  import sbe_pkg::*;

  // opcodes beyond the last defined instruction
  localparam logic [3:0] OP_SPARE_A = 4'd14;
  localparam logic [3:0] OP_SPARE_B = 4'd15;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int LONG_HOLD = 400;

  typedef struct packed {
    kind_t       kind;
    err_t        code;
    logic [31:0] value;
    logic        last;
  } outcome_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [3:0] op = OP_HALT;
  logic signed [31:0] arg = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] kind;
  logic [2:0] error_code;
  logic signed [31:0] value;
  logic last;

  // shadow machine state
  logic [31:0] shadow_stack [DefStackDepth];
  logic [31:0] shadow_store [DefStoreDepth];
  int unsigned shadow_sp = 0;
  bit shadow_halted = 1'b0;

  outcome_t pending_outputs[$];
  int fail_count = 0;
  int instr_count = 0;
  int output_count = 0;
  int cycle_count = 0;
  bit hold_request = 1'b0;

  stack_bytecode_executor uut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .op(op), .arg(arg), .out_valid(out_valid), .out_ready(out_ready),
    .kind(kind), .error_code(error_code), .value(value), .last(last)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // timeout watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic post_outcome(kind_t k, err_t c, logic [31:0] v, logic l);
    outcome_t o;
    o.kind = k;
    o.code = c;
    o.value = v;
    o.last = l;
    pending_outputs.push_back(o);
  endtask

  task automatic halt_with(err_t c);
    shadow_halted = 1'b1;
    post_outcome(KIND_ERROR, c, '0, 1'b1);
  endtask

  // predict the outputs of one accepted instruction
  task automatic execute_shadow(logic [3:0] code, logic [31:0] imm);
    logic [31:0] lhs, rhs, res;
    longint quot;
    if (shadow_halted) return;
    case (code)
      OP_HALT: begin
        shadow_halted = 1'b1;
        post_outcome(KIND_HALT, ERR_OVERFLOW, '0, 1'b1);
      end
      OP_GETL, OP_GETG: begin
        if (imm >= DefStoreDepth) halt_with(ERR_INDEX);
        else if (shadow_sp >= DefStackDepth) halt_with(ERR_OVERFLOW);
        else begin
          shadow_stack[shadow_sp] = shadow_store[imm[7:0]];
          shadow_sp++;
        end
      end
      OP_SETL, OP_SETG: begin
        if (imm >= DefStoreDepth) halt_with(ERR_INDEX);
        else if (shadow_sp == 0) halt_with(ERR_UNDERFLOW);
        else begin
          shadow_sp--;
          shadow_store[imm[7:0]] = shadow_stack[shadow_sp];
        end
      end
      OP_PUSH: begin
        if (shadow_sp >= DefStackDepth) halt_with(ERR_OVERFLOW);
        else begin
          shadow_stack[shadow_sp] = imm;
          shadow_sp++;
        end
      end
      OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
        if (shadow_sp < 2) halt_with(ERR_UNDERFLOW);
        else begin
          rhs = shadow_stack[shadow_sp-1];
          lhs = shadow_stack[shadow_sp-2];
          if (code == OP_DIV && rhs == 0) halt_with(ERR_DIV_ZERO);
          else begin
            case (code)
              OP_ADD: res = lhs + rhs;
              OP_SUB: res = lhs - rhs;
              OP_MUL: res = lhs * rhs;
              default: begin
                quot = longint'($signed(lhs)) / longint'($signed(rhs));
                res = quot[31:0];
              end
            endcase
            shadow_sp--;
            shadow_stack[shadow_sp-1] = res;
          end
        end
      end
      OP_NEG: begin
        if (shadow_sp == 0) halt_with(ERR_UNDERFLOW);
        else shadow_stack[shadow_sp-1] = 32'd0 - shadow_stack[shadow_sp-1];
      end
      OP_SHOW: begin
        if (imm > PrintMax) halt_with(ERR_INDEX);
        else if (imm > shadow_sp) halt_with(ERR_UNDERFLOW);
        else begin
          for (int i = 0; i < int'(imm); i++)
            post_outcome(KIND_PRINT, ERR_OVERFLOW, shadow_stack[shadow_sp - imm + i],
                         i + 1 == int'(imm));
          shadow_sp -= imm;
        end
      end
      default: halt_with(ERR_UNSUPPORTED);
    endcase
  endtask

  // send one instruction transaction, with a random gap before it
  task automatic send_instr(logic [3:0] code, logic [31:0] imm);
    int gap;
    gap = $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= code;
    arg <= imm;
    do @(posedge clk); while (!in_ready);
    instr_count++;
    execute_shadow(code, imm);
  endtask

  // output side: random stalls per transaction, one long hold on request
  initial begin
    int stall;
    @(negedge rst);
    forever begin
      stall = $urandom_range(0, 4);
      if (hold_request) begin
        stall = LONG_HOLD;
        hold_request = 1'b0;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // result checker
  always @(posedge clk) begin
    outcome_t exp_o;
    if (!rst && out_valid && out_ready) begin
      output_count <= output_count + 1;
      if (pending_outputs.size() == 0) begin
        $error("unexpected result kind=%0d value=%0d", kind, value);
        fail_count++;
      end else begin
        exp_o = pending_outputs.pop_front();
        if (kind !== exp_o.kind) begin
          $error("kind: expected %0d actual %0d", exp_o.kind, kind);
          fail_count++;
        end
        if (error_code !== exp_o.code) begin
          $error("error_code: expected %0d actual %0d", exp_o.code, error_code);
          fail_count++;
        end
        if (value !== exp_o.value) begin
          $error("value: expected %0d actual %0d", $signed(exp_o.value), value);
          fail_count++;
        end
        if (last !== exp_o.last) begin
          $error("last: expected %0d actual %0d", exp_o.last, last);
          fail_count++;
        end
      end
    end
  end

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return 32'd0;
      4: return 32'($urandom_range(0, 20)) - 32'd10;
      default: return $urandom;
    endcase
  endfunction

  // extremes, every supported instruction except halt, wrap and truncation cases
  task automatic test_directed();
    send_instr(OP_GETG, 32'd17);          // never written store entry reads zero
    send_instr(OP_PUSH, 32'h7fff_ffff);
    send_instr(OP_PUSH, 32'd1);
    send_instr(OP_ADD, '0);               // wraps to minimum
    send_instr(OP_PUSH, 32'hffff_ffff);
    send_instr(OP_DIV, '0);               // minimum by minus one
    send_instr(OP_SETL, 32'd255);
    send_instr(OP_GETG, 32'd255);
    send_instr(OP_NEG, '0);               // negated minimum stays minimum
    send_instr(OP_PUSH, -32'sd7);
    send_instr(OP_PUSH, 32'd2);
    send_instr(OP_DIV, '0);               // truncates toward zero
    send_instr(OP_PUSH, 32'd3);
    send_instr(OP_SUB, '0);
    send_instr(OP_PUSH, 32'h0001_0001);
    send_instr(OP_MUL, '0);
    send_instr(OP_SETG, 32'd0);
    send_instr(OP_GETL, 32'd0);
    send_instr(OP_SHOW, 32'd0);           // empty print gives nothing
    send_instr(OP_SHOW, 32'd3);
  endtask

  // well-formed random instructions with random content
  task automatic test_random(int count);
    int sent;
    int choice;
    int unsigned lim;
    logic [3:0] code;
    sent = 0;
    while (sent < count) begin
      choice = $urandom_range(0, 7);
      code = OP_HALT;
      case (choice)
        0, 1: if (shadow_sp < 200) begin
          send_instr(OP_PUSH, pick_value());
          sent++;
        end
        2: if (shadow_sp < 200) begin
          send_instr($urandom_range(0, 1) ? OP_GETL : OP_GETG, $urandom_range(0, 255));
          sent++;
        end
        3: if (shadow_sp > 0) begin
          send_instr($urandom_range(0, 1) ? OP_SETL : OP_SETG, $urandom_range(0, 255));
          sent++;
        end
        4: if (shadow_sp >= 2) begin
          case ($urandom_range(0, 3))
            0: code = OP_ADD;
            1: code = OP_SUB;
            2: code = OP_MUL;
            default: code = (shadow_stack[shadow_sp-1] != 0) ? OP_DIV : OP_ADD;
          endcase
          send_instr(code, $urandom);
          sent++;
        end
        5: if (shadow_sp > 0) begin
          send_instr(OP_NEG, $urandom);
          sent++;
        end
        default: if (shadow_sp > 0) begin
          lim = (shadow_sp < PrintMax) ? shadow_sp : PrintMax;
          if ($urandom_range(0, 5) != 0 && lim > 6) lim = 6;
          send_instr(OP_SHOW, $urandom_range(0, lim));
          sent++;
        end
      endcase
    end
  endtask

  // output held off for a long stretch while further instructions wait at the input
  task automatic test_backpressure();
    while (shadow_sp < 70) send_instr(OP_PUSH, $urandom);
    hold_request = 1'b1;
    send_instr(OP_SHOW, PrintMax);
    send_instr(OP_PUSH, 32'd5);
    send_instr(OP_SHOW, 32'd4);
  endtask

  // one terminal event, then instructions that must be ignored
  task automatic test_terminal();
    case ($urandom_range(0, 6))
      0: send_instr(OP_HALT, $urandom);
      1: begin
        while (shadow_sp < DefStackDepth) send_instr(OP_PUSH, $urandom);
        send_instr(OP_PUSH, 32'd1);
      end
      2: begin
        while (shadow_sp > 0)
          send_instr(OP_SHOW, (shadow_sp < PrintMax) ? shadow_sp : PrintMax);
        send_instr(OP_ADD, '0);
      end
      3: begin
        send_instr(OP_PUSH, 32'd9);
        send_instr(OP_PUSH, 32'd0);
        send_instr(OP_DIV, '0);
      end
      4: send_instr(OP_GETG, $urandom_range(0, 1) ? 32'hffff_ffff : 32'd256);
      5: send_instr(OP_SHOW, 32'd65);
      default: case ($urandom_range(0, 3))
        0: send_instr(OP_CALL, '0);
        1: send_instr(OP_RET, '0);
        2: send_instr(OP_SPARE_A, '0);
        default: send_instr(OP_SPARE_B, '0);
      endcase
    endcase
    send_instr(OP_PUSH, 32'd1);
    send_instr(OP_SHOW, 32'd1);
    send_instr(OP_HALT, '0);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random(100);
    test_backpressure();
    test_random(100);
    test_terminal();
    in_valid <= 1'b0;
    while (pending_outputs.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("run covered %0d instructions and %0d results", instr_count, output_count);
    $display("directed, random, long output hold and one terminal event");
    if (fail_count == 0 && pending_outputs.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
